>>> rtl/gb5_pkg.sv
// package for the 5x5 gaussian blur unit: widths, kernel and helpers
package gb5_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int WIN        = 5;
  localparam int PIX_W      = 32;
  localparam int WCFG_W     = 12;
  localparam int HCFG_W     = 13;
  localparam int CFG_DATA_W = 13;
  localparam int ROW_W      = 13;
  localparam int ACC_W      = 16;
  localparam int WSUM_W     = 8;

  localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_INCLUDE_ALPHA = 2'd2;

  localparam logic       KIND_PIXEL = 1'b0;
  localparam logic       KIND_FLUSH = 1'b1;

  // kernel weight of tap (row, column)
  function automatic logic [3:0] kern(input int r, input int c);
    logic [3:0] k [5][5];
    k = '{'{4'd2, 4'd4, 4'd5, 4'd4, 4'd2},
          '{4'd4, 4'd9, 4'd12, 4'd9, 4'd4},
          '{4'd5, 4'd12, 4'd15, 4'd12, 4'd5},
          '{4'd4, 4'd9, 4'd12, 4'd9, 4'd4},
          '{4'd2, 4'd4, 4'd5, 4'd4, 4'd2}};
    return k[r][c];
  endfunction

  // control travelling with a column down the cell chain
  typedef struct packed {
    logic             vld;
    logic [4:0]       rmask;
    logic [4:0]       cmask;
    logic             last;
  } gb5_tag_t;

endpackage

>>> rtl/gb5_ram.sv
// generic single write, single registered read ram
module gb5_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule

>>> rtl/gb5_cell.sv
// one window column cell: holds the five pixels of one window column
module gb5_cell (
  input  logic                          clk,
  input  logic                          shift,
  input  logic [5*gb5_pkg::PIX_W-1:0]   col_in,
  output logic [5*gb5_pkg::PIX_W-1:0]   col_r
);
  always_ff @(posedge clk) begin
    if (shift) col_r <= col_in;
  end
endmodule

>>> rtl/gb5_div.sv
// sequential restoring divider for four channel sums by one weight sum
module gb5_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [4*gb5_pkg::ACC_W-1:0]   num,
  input  logic [gb5_pkg::WSUM_W-1:0]    den,
  output logic                          busy,
  output logic                          done,
  output logic [31:0]                   quo
);
  localparam int AW = gb5_pkg::ACC_W;
  localparam int DW = gb5_pkg::WSUM_W;
  logic [AW-1:0]       n_r   [4];
  logic [DW:0]         rem_r [4];
  logic [DW-1:0]       den_r;
  logic [$clog2(AW+1)-1:0] cnt_r;
  logic                busy_r, done_r;
  logic [DW+1:0]       trial [4];

  always_comb begin
    for (int c = 0; c < 4; c++) trial[c] = {rem_r[c], n_r[c][AW-1]} - {2'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        den_r  <= den;
        for (int c = 0; c < 4; c++) begin
          n_r[c]   <= num[c*AW +: AW];
          rem_r[c] <= '0;
        end
      end else if (busy_r) begin
        for (int c = 0; c < 4; c++) begin
          if (!trial[c][DW+1]) rem_r[c] <= trial[c][DW:0];
          else rem_r[c] <= {rem_r[c][DW-1:0], n_r[c][AW-1]};
          n_r[c] <= {n_r[c][AW-2:0], ~trial[c][DW+1]};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ($clog2(AW+1))'(AW-1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  always_comb begin
    for (int c = 0; c < 4; c++) quo[c*8 +: 8] = n_r[c][7:0];
  end
endmodule

>>> rtl/gaussian_blur_5x5_rgba_unit.sv
// top level of the 5x5 gaussian blur unit for rgba pixel streams
// One word at a time: an accepted word reads four line-store rows (one
// registered ram read), shifts a new column into a chain of five column
// cells, then, when an output is due, forms the weighted 5x5 sums (one
// cell column per cycle) and divides by the in-range weight sum in a
// 16-step restoring divider shared by the four channels. A word that is
// ignored (pixel after the frame end, flush before it) is accepted and
// dropped. The result sits in an output register so the next word may be
// accepted while it waits. Borders drop out-of-image taps. No clearing
// pass: unwritten line-store entries only feed dropped taps.
module gaussian_blur_5x5_rgba_unit #(
  parameter int MAX_WIDTH = gb5_pkg::MAX_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [gb5_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_kind,
  input  logic [7:0]                      in_red,
  input  logic [7:0]                      in_green,
  input  logic [7:0]                      in_blue,
  input  logic [7:0]                      in_alpha,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_red,
  output logic [7:0]                      out_green,
  output logic [7:0]                      out_blue,
  output logic [7:0]                      out_alpha,
  output logic                            out_frame_last
);
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int AW = XW + 2;
  localparam int PW = gb5_pkg::PIX_W;
  localparam int RW = gb5_pkg::ROW_W;
  localparam int CW = XW + 1;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_SHIFT, S_ACC, S_DIV, S_OUT} state_t;

  // configuration
  logic [gb5_pkg::WCFG_W-1:0] fw_r;
  logic [gb5_pkg::HCFG_W-1:0] fh_r;
  logic                       inc_alpha_r;
  logic [CW-1:0]              w_eff;
  logic [RW-1:0]              h_eff;

  always_comb begin
    // zero acts as one, oversize clamps
    if (fw_r == '0) w_eff = CW'(1);
    else if (32'(fw_r) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(fw_r);
    if (fh_r == '0) h_eff = RW'(1);
    else if (32'(fh_r) > gb5_pkg::MAX_HEIGHT) h_eff = RW'(gb5_pkg::MAX_HEIGHT);
    else h_eff = RW'(fh_r);
  end

  state_t         state_r;
  logic [XW-1:0]  in_col_r;
  logic [RW-1:0]  in_row_r;
  logic [CW-1:0]  out_col_r;
  logic [RW-1:0]  out_row_r;
  logic [PW-1:0]  pix_r;
  logic [2:0]     acc_cnt_r;
  logic [1:0]     rd_sel_r;
  logic [PW-1:0]  rd_data [4];
  logic [5*PW-1:0] col [5];
  logic [5*PW-1:0] new_col;
  logic            shift;
  logic [gb5_pkg::ACC_W-1:0] acc_r [4];
  logic [gb5_pkg::WSUM_W-1:0] wsum_r;
  logic            last_r;
  logic            div_start, div_busy, div_done;
  logic [31:0]     quo;
  logic            obuf_vld_r;
  logic [7:0]      o_r, o_g, o_b, o_a;
  logic            o_last;
  logic            in_acc, out_acc;
  logic            item_ok;
  logic            due;
  logic [RW+XW:0]  n_pos;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = (state_r != S_IDLE) || cfg_we;
  // pixel needs frame open, flush needs frame fully read
  assign item_ok = (in_kind == gb5_pkg::KIND_PIXEL) ? (in_row_r < h_eff) : (in_row_r >= h_eff);

  // line store: four rows, one ram each, written with current pixel row
  for (genvar k = 0; k < 4; k++) begin : g_line
    gb5_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_ram (
      .clk     (clk),
      .wr_en   (state_r == S_READ && in_row_r[1:0] == 2'(k)),
      .wr_addr (in_col_r),
      .wr_data (pix_r),
      .rd_en   (state_r == S_READ),
      .rd_addr (in_col_r),
      .rd_data (rd_data[k])
    );
  end

  always_comb begin
    // window row 4-k takes row r-k, r being the row of the word just read
    for (int k = 1; k <= 4; k++)
      new_col[(4-k)*PW +: PW] = rd_data[rd_sel_r - 2'(k)];
    new_col[4*PW +: PW] = pix_r;
  end

  // cell chain: data moves from cell 4 (newest) toward cell 0
  assign shift = (state_r == S_SHIFT) || (state_r == S_ACC);
  for (genvar c = 0; c < 5; c++) begin : g_cell
    logic [5*PW-1:0] cin;
    // in accumulate state the chain rotates so each column passes cell 0
    if (c == 4) begin : g_head
      assign cin = (state_r == S_SHIFT) ? new_col : col[0];
    end else begin : g_body
      assign cin = col[c+1];
    end
    gb5_cell u_cell (.clk(clk), .shift(shift), .col_in(cin), .col_r(col[c]));
  end

  // weighted column sum of cell 0 (column index acc_cnt_r)
  logic [gb5_pkg::ACC_W-1:0] csum [4];
  logic [gb5_pkg::WSUM_W-1:0] cw;
  logic                      cok;
  always_comb begin
    logic signed [CW+1:0] xx;
    logic signed [RW+1:0] yy;
    xx = $signed({2'b0, out_col_r}) + $signed((CW+2)'(acc_cnt_r)) - (CW+2)'(2);
    cok = (xx >= 0) && (xx < $signed({2'b0, w_eff}));
    cw = '0;
    for (int ch = 0; ch < 4; ch++) csum[ch] = '0;
    for (int r = 0; r < 5; r++) begin
      yy = $signed({2'b0, out_row_r}) + (RW+2)'(r) - (RW+2)'(2);
      if (cok && yy >= 0 && yy < $signed({2'b0, h_eff})) begin
        cw = cw + gb5_pkg::WSUM_W'(gb5_pkg::kern(r, int'(acc_cnt_r)));
        for (int ch = 0; ch < 4; ch++)
          csum[ch] = csum[ch] + gb5_pkg::ACC_W'(col[0][r*PW + ch*8 +: 8]
                     * gb5_pkg::kern(r, int'(acc_cnt_r)));
      end
    end
  end

  assign n_pos = (RW+XW+1)'(in_row_r) * (RW+XW+1)'(w_eff) + (RW+XW+1)'(in_col_r);
  assign div_start = (state_r == S_ACC) && (acc_cnt_r == 3'd4);

  gb5_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num({acc_r[3] + csum[3], acc_r[2] + csum[2], acc_r[1] + csum[1], acc_r[0] + csum[0]}),
    .den(wsum_r + cw), .busy(div_busy), .done(div_done), .quo(quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fw_r        <= gb5_pkg::WCFG_W'(640);
      fh_r        <= gb5_pkg::HCFG_W'(480);
      inc_alpha_r <= 1'b0;
      in_col_r    <= '0;
      in_row_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      obuf_vld_r  <= 1'b0;
      acc_cnt_r   <= '0;
      rd_sel_r    <= '0;
      due         <= 1'b0;
    end else begin
      if (out_acc) obuf_vld_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          gb5_pkg::REG_FRAME_WIDTH:   fw_r <= cfg_data[gb5_pkg::WCFG_W-1:0];
          gb5_pkg::REG_FRAME_HEIGHT:  fh_r <= cfg_data;
          gb5_pkg::REG_INCLUDE_ALPHA: inc_alpha_r <= cfg_data[0];
          default: ;
        endcase
        if (cfg_index <= gb5_pkg::REG_INCLUDE_ALPHA) begin
          in_col_r <= '0; in_row_r <= '0; out_col_r <= '0; out_row_r <= '0;
        end
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && item_ok) begin
            pix_r   <= (in_kind == gb5_pkg::KIND_FLUSH) ? '0 :
                       {in_alpha, in_blue, in_green, in_red};
            state_r <= S_READ;
          end
        end
        S_READ: begin
          due <= n_pos >= (RW+XW+1)'({w_eff, 1'b0}) + (RW+XW+1)'(2);
          rd_sel_r <= in_row_r[1:0];
          if (CW'(in_col_r) + CW'(1) >= w_eff) begin
            in_col_r <= '0;
            in_row_r <= in_row_r + 1'b1;
          end else begin
            in_col_r <= in_col_r + 1'b1;
          end
          state_r <= S_SHIFT;
        end
        S_SHIFT: begin
          acc_cnt_r <= '0;
          for (int ch = 0; ch < 4; ch++) acc_r[ch] <= '0;
          wsum_r  <= '0;
          state_r <= (due && !obuf_vld_r) ? S_ACC : (due ? S_OUT : S_IDLE);
        end
        S_ACC: begin
          for (int ch = 0; ch < 4; ch++) acc_r[ch] <= acc_r[ch] + csum[ch];
          wsum_r    <= wsum_r + cw;
          acc_cnt_r <= acc_cnt_r + 1'b1;
          if (acc_cnt_r == 3'd4) state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            o_r <= quo[7:0]; o_g <= quo[15:8]; o_b <= quo[23:16];
            o_a <= inc_alpha_r ? quo[31:24] : 8'hff;
            obuf_vld_r <= 1'b1;
            if (out_row_r + 1'b1 >= h_eff && out_col_r + 1'b1 >= w_eff) begin
              o_last <= 1'b1;
              in_col_r <= '0; in_row_r <= '0; out_col_r <= '0; out_row_r <= '0;
            end else begin
              o_last <= 1'b0;
              if (out_col_r + 1'b1 >= w_eff) begin
                out_col_r <= '0;
                out_row_r <= out_row_r + 1'b1;
              end else begin
                out_col_r <= out_col_r + 1'b1;
              end
            end
            state_r <= S_IDLE;
          end
        end
        S_OUT: begin
          // wait for the output register to free up
          if (!obuf_vld_r || out_acc) state_r <= S_ACC;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign last_r        = o_last;
  assign out_valid     = obuf_vld_r;
  assign out_red       = o_r;
  assign out_green     = o_g;
  assign out_blue      = o_b;
  assign out_alpha     = o_a;
  assign out_frame_last = last_r;

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_acc) else $error("word accepted while busy");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && div_done) |-> !obuf_vld_r) else $error("output overwritten");
`endif
endmodule

>>> tb/sv/gaussian_blur_5x5_rgba_unit_tb.sv
// testbench for the 5x5 gaussian blur rgba unit: predicted frames checked word by word
`timescale 1ns / 100ps

module gaussian_blur_5x5_rgba_unit_tb;

  localparam int LINE_W    = 2048;
  localparam int CYCLE_CAP = 3000000;

  // one input word and one blurred result word
  typedef struct packed {
    logic       kind;
    logic [7:0] red, green, blue, alpha;
  } pix_word_t;

  typedef struct packed {
    logic [7:0] red, green, blue, alpha;
    logic       last;
  } blur_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = gb5_pkg::REG_FRAME_WIDTH;
  logic [gb5_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = gb5_pkg::KIND_PIXEL;
  logic [7:0] in_red = '0, in_green = '0, in_blue = '0, in_alpha = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_red, out_green, out_blue, out_alpha;
  logic out_frame_last;

  gaussian_blur_5x5_rgba_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue), .in_alpha(in_alpha),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_alpha(out_alpha), .out_frame_last(out_frame_last)
  );

  always #6 clk = ~clk;

  // shadow copy of the unit's state
  logic [11:0] sh_width = 12'd640;
  logic [12:0] sh_height = 13'd480;
  logic        sh_alpha_en = 1'b0;
  logic [31:0] rows_mem [0:4*LINE_W-1];
  logic [31:0] win_pix [0:24];
  int unsigned col_in, row_in, col_out, row_out;

  pix_word_t  word_queue[$];
  blur_word_t blur_expected[$];
  int         idle_mode = 0;   // 0 none, 1 sender 48%, 2 receiver 48%, 3 both 9%
  int         mismatches = 0;
  int         words_checked = 0;
  int         random_words = 0;
  int         frames_done = 0;
  int         cfg_writes = 0;
  longint     cycle_count = 0;

  function automatic int kern_weight(input int r, input int c);
    int k [5][5];
    k = '{'{2, 4, 5, 4, 2}, '{4, 9, 12, 9, 4}, '{5, 12, 15, 12, 5},
          '{4, 9, 12, 9, 4}, '{2, 4, 5, 4, 2}};
    return k[r][c];
  endfunction

  // one accepted word through the shadow model; returns 1 when a pixel comes out
  function automatic bit blur_advance(input pix_word_t wd, output blur_word_t res);
    int unsigned w, h, r, x, wsum;
    int unsigned acc [4];
    logic [31:0] pix, p;
    longint unsigned n;
    int yy, xx, f;
    w = (sh_width == 0) ? 1 : ((sh_width > LINE_W) ? LINE_W : sh_width);
    h = (sh_height == 0) ? 1 :
        ((sh_height > gb5_pkg::MAX_HEIGHT) ? gb5_pkg::MAX_HEIGHT : sh_height);
    res = '0;
    if (wd.kind == gb5_pkg::KIND_PIXEL) begin
      if (row_in >= h) return 0;
      pix = {wd.alpha, wd.blue, wd.green, wd.red};
    end else begin
      if (row_in < h) return 0;
      pix = '0;
    end
    // shift a new column into the window from the line store
    r = row_in;
    x = col_in % LINE_W;
    for (int k = 0; k < 5; k++)
      for (int c = 0; c < 4; c++)
        win_pix[k*5+c] = win_pix[k*5+c+1];
    for (int k = 1; k <= 4; k++)
      win_pix[(4-k)*5+4] = rows_mem[((r - k) & 3) * LINE_W + x];
    win_pix[24] = pix;
    rows_mem[(r & 3) * LINE_W + x] = pix;
    n = longint'(r) * w + x;
    if (x + 1 >= w) begin
      col_in = 0;
      row_in = r + 1;
    end else
      col_in = x + 1;
    if (n < 2 * longint'(w) + 2) return 0;
    // weighted sum over in-image taps only
    wsum = 0;
    for (int ch = 0; ch < 4; ch++) acc[ch] = 0;
    for (int i = 0; i < 5; i++) begin
      yy = int'(row_out) + i - 2;
      if (yy < 0 || yy >= int'(h)) continue;
      for (int j = 0; j < 5; j++) begin
        xx = int'(col_out) + j - 2;
        if (xx < 0 || xx >= int'(w)) continue;
        f = kern_weight(i, j);
        p = win_pix[i*5+j];
        wsum += f;
        for (int ch = 0; ch < 4; ch++) acc[ch] += ((p >> (8*ch)) & 32'hff) * f;
      end
    end
    res.red   = (wsum != 0) ? 8'(acc[0] / wsum) : 8'd0;
    res.green = (wsum != 0) ? 8'(acc[1] / wsum) : 8'd0;
    res.blue  = (wsum != 0) ? 8'(acc[2] / wsum) : 8'd0;
    res.alpha = !sh_alpha_en ? 8'hff : ((wsum != 0) ? 8'(acc[3] / wsum) : 8'd0);
    if (row_out + 1 >= h && col_out + 1 >= w) begin
      res.last = 1'b1;
      col_in = 0; row_in = 0; col_out = 0; row_out = 0;
    end else if (col_out + 1 >= w) begin
      col_out = 0;
      row_out++;
    end else
      col_out++;
    return 1;
  endfunction

  // queue a word and its expected result, if any
  task automatic push_word(input pix_word_t wd, output bit last);
    blur_word_t res;
    last = 1'b0;
    if (blur_advance(wd, res)) begin
      blur_expected.push_back(res);
      last = res.last;
    end
    word_queue.push_back(wd);
  endtask

  function automatic pix_word_t rand_pixel(input bit extreme);
    pix_word_t wd;
    wd.kind  = gb5_pkg::KIND_PIXEL;
    wd.red   = extreme ? ($urandom_range(1) ? 8'hff : 8'h00) : 8'($urandom);
    wd.green = extreme ? ($urandom_range(1) ? 8'hff : 8'h00) : 8'($urandom);
    wd.blue  = extreme ? ($urandom_range(1) ? 8'hff : 8'h00) : 8'($urandom);
    wd.alpha = extreme ? ($urandom_range(1) ? 8'hff : 8'h00) : 8'($urandom);
    return wd;
  endfunction

  function automatic bit row_in_done();
    int unsigned h;
    h = (sh_height == 0) ? 1 :
        ((sh_height > gb5_pkg::MAX_HEIGHT) ? gb5_pkg::MAX_HEIGHT : sh_height);
    return row_in >= h;
  endfunction

  // one frame: pixels then flush ticks until the marked last pixel;
  // noisy frames add early flushes and surplus pixels, a partial frame stops short
  task automatic send_frame(input bit extreme, input bit noisy, input bit partial,
                            input bit counted);
    bit last;
    int stop_at;
    int sent;
    pix_word_t wd;
    last = 1'b0;
    sent = 0;
    stop_at = partial ? $urandom_range(1, 12) : -1;
    while (!last && sent != stop_at) begin
      if (noisy && $urandom_range(99) < 6) begin
        wd = rand_pixel(extreme);
        // ignored by the unit
        wd.kind = ~row_in_done() ? gb5_pkg::KIND_FLUSH : gb5_pkg::KIND_PIXEL;
      end else if (!row_in_done())
        wd = rand_pixel(extreme || $urandom_range(99) < 5);
      else begin
        wd = rand_pixel(1'b0);   // payload of a flush is ignored
        wd.kind = gb5_pkg::KIND_FLUSH;
      end
      push_word(wd, last);
      sent++;
      if (counted) random_words++;
    end
    if (last) frames_done++;
  endtask

  // wait until nothing is in flight, then let the unit settle
  task automatic wait_drained();
    while (word_queue.size() != 0 || in_valid || blur_expected.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= gb5_pkg::CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      gb5_pkg::REG_FRAME_WIDTH:   sh_width = 12'(val);
      gb5_pkg::REG_FRAME_HEIGHT:  sh_height = 13'(val);
      gb5_pkg::REG_INCLUDE_ALPHA: sh_alpha_en = val[0];
      default: ;
    endcase
    col_in = 0; row_in = 0; col_out = 0; row_out = 0;
    cfg_writes++;
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h, input bit alpha_en);
    wait_drained();
    write_reg(gb5_pkg::REG_FRAME_WIDTH, w);
    write_reg(gb5_pkg::REG_FRAME_HEIGHT, h);
    write_reg(gb5_pkg::REG_INCLUDE_ALPHA, alpha_en);
  endtask

  // driver: presents queued words, gaps at random in idle modes 1 and 3
  always @(posedge clk) begin
    bit gap;
    pix_word_t wd;
    gap = (idle_mode == 1) ? ($urandom_range(99) < 48) :
          (idle_mode == 3) ? ($urandom_range(99) < 9) : 1'b0;
    if (!rst_n)
      in_valid <= 1'b0;
    else if (!in_valid || !in_stall) begin
      if (word_queue.size() != 0 && !gap) begin
        wd = word_queue.pop_front();
        in_valid <= 1'b1;
        in_kind  <= wd.kind;
        in_red   <= wd.red;
        in_green <= wd.green;
        in_blue  <= wd.blue;
        in_alpha <= wd.alpha;
      end else
        in_valid <= 1'b0;
    end
  end

  // monitor: checks each accepted result against the oldest prediction
  always @(posedge clk) begin
    blur_word_t want;
    blur_word_t got;
    cycle_count <= cycle_count + 1;
    out_stall <= (idle_mode == 2) ? ($urandom_range(99) < 48) :
                 (idle_mode == 3) ? ($urandom_range(99) < 9) : 1'b0;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_red, out_green, out_blue, out_alpha, out_frame_last};
      if (blur_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word %h at cycle %0d", got, cycle_count);
      end else begin
        want = blur_expected.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch word %0d: expected r%h g%h b%h a%h last%b, %s",
                     words_checked, want.red, want.green, want.blue, want.alpha,
                     want.last, $sformatf("got r%h g%h b%h a%h last%b",
                     got.red, got.green, got.blue, got.alpha, got.last));
        end
        words_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycle_count > CYCLE_CAP) begin
      $display("FAIL gaussian_blur_5x5_rgba_unit");
      $finish;
    end
  end

  initial begin
    int phase;
    for (int i = 0; i < 4*LINE_W; i++) rows_mem[i] = '0;
    for (int i = 0; i < 25; i++) win_pix[i] = '0;
    col_in = 0; row_in = 0; col_out = 0; row_out = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: saturated values, tiny frames, out of range sizes, noise words
    set_frame(3, 2, 1'b1);
    send_frame(1'b1, 1'b0, 1'b0, 1'b0);
    set_frame(0, 1, 1'b0);           // zero width acts as one pixel
    send_frame(1'b1, 1'b1, 1'b0, 1'b0);
    set_frame(5, 0, 1'b1);           // zero height acts as one row
    send_frame(1'b1, 1'b1, 1'b0, 1'b0);

    // random frames with small sizes across all idle modes
    phase = 0;
    while (random_words < 750) begin
      set_frame($urandom_range(1, 9), $urandom_range(1, 7), $urandom_range(1));
      idle_mode = phase % 4;
      repeat ($urandom_range(1, 3))
        send_frame(1'b0, $urandom_range(99) < 30, 1'b0, 1'b1);
      if ($urandom_range(99) < 20) send_frame(1'b0, 1'b0, 1'b1, 1'b1);  // abandoned
      phase++;
    end

    // starts of frames at the largest sizes and above the limits
    idle_mode = 0;
    set_frame(gb5_pkg::MAX_WIDTH, 1, 1'b1);
    send_frame(1'b0, 1'b0, 1'b1, 1'b0);
    set_frame(4095, 2, 1'b0);
    send_frame(1'b0, 1'b0, 1'b1, 1'b0);
    set_frame(1, gb5_pkg::MAX_HEIGHT, 1'b1);
    send_frame(1'b0, 1'b0, 1'b1, 1'b0);
    set_frame(1, 8191, 1'b0);
    send_frame(1'b0, 1'b0, 1'b1, 1'b0);

    wait_drained();
    $display("covered %0d frames, %0d result words checked, %0d register writes",
             frames_done, words_checked, cfg_writes);
    $display("small frames in full, large and oversize frames only begun, alpha on and off");
    if (mismatches == 0 && blur_expected.size() == 0)
      $display("PASS gaussian_blur_5x5_rgba_unit");
    else
      $display("FAIL gaussian_blur_5x5_rgba_unit");
    $finish;
  end

endmodule
